/* src/word_frame_receiver_crc16_assert.svh */
// Assertion macros shared by the checker of the word frame receiver.
`ifndef WORD_FRAME_RECEIVER_CRC16_ASSERT_SVH
`define WORD_FRAME_RECEIVER_CRC16_ASSERT_SVH

// Antecedent and consequent in the same cycle.
`define WFR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("word frame receiver check failed");

// Consequent in the cycle after the antecedent.
`define WFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("word frame receiver check failed");

`endif

/* src/wfr_pkg.sv */
// Package with the types and constants of the word frame receiver.
`default_nettype none

package wfr_pkg;

  localparam int unsigned MAX_PAYLOAD = 1024;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  typedef enum logic {
    PHASE_HEADER,
    PHASE_BODY
  } phase_e;

  typedef enum logic [1:0] {
    KIND_MORE      = 2'd0,
    KIND_GOOD      = 2'd1,
    KIND_BAD_CRC   = 2'd2,
    KIND_TOO_LARGE = 2'd3
  } result_kind_e;

  typedef struct packed {
    result_kind_e kind;
    logic [15:0]  command_type;
    logic [31:0]  payload_word;
    logic [2:0]   payload_bytes;
    logic         frame_last;
  } result_t;

endpackage

`default_nettype wire

/* src/wfr_in_reg.sv */
// Input register stage that holds one received link word.
`default_nettype none

module wfr_in_reg (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] link_word_i,
  input  wire logic        take_i,
  output logic             valid_o,
  output logic [31:0]      word_o
);

  logic        valid_q, valid_d;
  logic [31:0] word_q;

  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      word_q <= link_word_i;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

`default_nettype wire

/* src/wfr_deframe.sv */
// Frame state, payload extraction and CRC-16 check for one link word.
`default_nettype none

module wfr_deframe #(
  parameter int unsigned MAX_PAYLOAD = wfr_pkg::MAX_PAYLOAD,
  localparam int unsigned SizeW = $clog2(MAX_PAYLOAD + 1)
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [31:0] word_i,
  input  wire logic        advance_i,
  output logic             res_valid_o,
  output wfr_pkg::result_t res_o,
  output logic [SizeW-1:0] res_size_o
);

  localparam int unsigned BlW = $clog2(MAX_PAYLOAD + 8);

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] x;
    x = crc[15:8] ^ b;
    x = x ^ (x >> 4);
    return (crc << 8) ^ ({8'h00, x} << 12) ^ ({8'h00, x} << 5) ^ {8'h00, x};
  endfunction

  wfr_pkg::phase_e  phase_q, phase_d;
  logic [15:0]      type_q, type_d;
  logic [SizeW-1:0] size_q, size_d;
  logic [BlW-1:0]   left_q, left_d;
  logic [15:0]      crc_q, crc_d;
  logic [7:0]       hi_q, hi_d;

  logic [7:0]  byte_w [4];
  logic [15:0] body_crc [5];
  logic [15:0] head_crc [5];
  logic [15:0] hdr_size;
  logic        too_large;
  logic [2:0]  pay_cnt;
  logic [31:0] pay_word;
  logic [15:0] pay_crc;
  logic [7:0]  crc_hi;
  logic [7:0]  crc_lo;
  logic        body_last;

  assign hdr_size  = word_i[15:0];
  assign too_large = hdr_size > 16'(MAX_PAYLOAD);
  assign body_last = left_q <= BlW'(4);

  always_comb begin
    body_crc[0] = crc_q;
    head_crc[0] = wfr_pkg::CRC_INIT;
    for (int p = 0; p < 4; p++) begin
      byte_w[p]     = word_i[31 - 8 * p -: 8];
      body_crc[p+1] = crc_byte(body_crc[p], byte_w[p]);
      head_crc[p+1] = crc_byte(head_crc[p], byte_w[p]);
    end
  end

  always_comb begin
    pay_cnt  = 3'd0;
    pay_word = '0;
    crc_hi   = hi_q;
    crc_lo   = 8'h00;
    for (int p = 0; p < 4; p++) begin
      if (left_q > BlW'(p + 2)) begin
        pay_word[31 - 8 * p -: 8] = byte_w[p];
        pay_cnt = pay_cnt + 3'd1;
      end
      if (left_q == BlW'(p + 2)) begin
        crc_hi = byte_w[p];
      end
      if (left_q == BlW'(p + 1)) begin
        crc_lo = byte_w[p];
      end
    end
  end

  always_comb begin
    case (pay_cnt)
      3'd1:    pay_crc = body_crc[1];
      3'd2:    pay_crc = body_crc[2];
      3'd3:    pay_crc = body_crc[3];
      3'd4:    pay_crc = body_crc[4];
      default: pay_crc = body_crc[0];
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      wfr_pkg::PHASE_HEADER: begin
        if (!too_large) begin
          phase_d = wfr_pkg::PHASE_BODY;
        end
      end
      wfr_pkg::PHASE_BODY: begin
        if (body_last) begin
          phase_d = wfr_pkg::PHASE_HEADER;
        end
      end
      default: phase_d = wfr_pkg::PHASE_HEADER;
    endcase
  end

  always_comb begin
    type_d = type_q;
    size_d = size_q;
    left_d = left_q;
    crc_d  = crc_q;
    hi_d   = hi_q;
    if (phase_q == wfr_pkg::PHASE_HEADER) begin
      if (!too_large) begin
        type_d = word_i[31:16];
        size_d = SizeW'(hdr_size);
        left_d = BlW'(hdr_size) + BlW'(2);
        crc_d  = head_crc[4];
        hi_d   = 8'h00;
      end
    end else begin
      left_d = body_last ? '0 : left_q - BlW'(4);
      crc_d  = pay_crc;
      hi_d   = crc_hi;
    end
  end

  always_comb begin
    res_o = '0;
    res_size_o = '0;
    case (phase_q)
      wfr_pkg::PHASE_HEADER: begin
        res_valid_o        = too_large;
        res_o.kind         = wfr_pkg::KIND_TOO_LARGE;
        res_o.command_type = word_i[31:16];
        res_o.frame_last   = 1'b1;
      end
      wfr_pkg::PHASE_BODY: begin
        res_valid_o         = 1'b1;
        res_o.command_type  = type_q;
        res_o.payload_word  = pay_word;
        res_o.payload_bytes = pay_cnt;
        res_o.frame_last    = body_last;
        res_size_o          = size_q;
        if (!body_last) begin
          res_o.kind = wfr_pkg::KIND_MORE;
        end else if ({crc_hi, crc_lo} == pay_crc) begin
          res_o.kind = wfr_pkg::KIND_GOOD;
        end else begin
          res_o.kind = wfr_pkg::KIND_BAD_CRC;
        end
      end
      default: begin
        res_valid_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= wfr_pkg::PHASE_HEADER;
      type_q  <= '0;
      size_q  <= '0;
      left_q  <= '0;
      crc_q   <= wfr_pkg::CRC_INIT;
      hi_q    <= '0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      type_q  <= type_d;
      size_q  <= size_d;
      left_q  <= left_d;
      crc_q   <= crc_d;
      hi_q    <= hi_d;
    end
  end

endmodule

`default_nettype wire

/* src/word_frame_receiver_crc16.sv */
// Top level of the length-prefixed word frame receiver with CRC-16 check.
// The block takes one 32-bit link word per cycle and sustains one transaction per
// cycle on both sides while out_ready_i stays high. A word is held in the input
// register, then decoded and checked by the combinational four-byte CRC-16 update,
// and its result is loaded into the result register when the word advances. Header
// words yield no result unless the payload size is above MAX_PAYLOAD. The input
// side keeps accepting while a result waits to be taken, until both the input and
// the result register are full.
`default_nettype none

module word_frame_receiver_crc16 #(
  parameter int unsigned MAX_PAYLOAD = wfr_pkg::MAX_PAYLOAD,
  localparam int unsigned SizeW = $clog2(MAX_PAYLOAD + 1)
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] link_word_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       result_kind_o,
  output logic [15:0]      command_type_o,
  output logic [SizeW-1:0] payload_size_o,
  output logic [31:0]      payload_word_o,
  output logic [2:0]       payload_bytes_o,
  output logic             frame_last_o
);

  logic             word_valid;
  logic [31:0]      word;
  logic             advance;
  logic             res_valid;
  wfr_pkg::result_t res;
  logic [SizeW-1:0] res_size;

  logic             out_valid_q, out_valid_d;
  wfr_pkg::result_t res_q;
  logic [SizeW-1:0] size_q;

  assign advance = word_valid && (!out_valid_q || out_ready_i);

  wfr_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .link_word_i (link_word_i),
    .take_i      (advance),
    .valid_o     (word_valid),
    .word_o      (word)
  );

  wfr_deframe #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_deframe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .word_i      (word),
    .advance_i   (advance),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_size_o  (res_size)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = res_valid;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      res_q  <= res;
      size_q <= res_size;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_kind_o   = res_q.kind;
  assign command_type_o  = res_q.command_type;
  assign payload_size_o  = size_q;
  assign payload_word_o  = res_q.payload_word;
  assign payload_bytes_o = res_q.payload_bytes;
  assign frame_last_o    = res_q.frame_last;

endmodule

`default_nettype wire

/* src/wfr_checker.sv */
// Port-level checker of the word frame receiver and its bind to the top level.
`default_nettype none

`include "word_frame_receiver_crc16_assert.svh"

module wfr_checker #(
  parameter int unsigned MAX_PAYLOAD = wfr_pkg::MAX_PAYLOAD,
  localparam int unsigned SizeW = $clog2(MAX_PAYLOAD + 1)
) (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             out_valid_i,
  input wire logic             out_ready_i,
  input wire logic [1:0]       result_kind_i,
  input wire logic [15:0]      command_type_i,
  input wire logic [SizeW-1:0] payload_size_i,
  input wire logic [31:0]      payload_word_i,
  input wire logic [2:0]       payload_bytes_i,
  input wire logic             frame_last_i
);

  `WFR_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i,
                   out_valid_i && $stable(result_kind_i) && $stable(command_type_i) &&
                   $stable(payload_word_i) && $stable(frame_last_i))

  `WFR_ASSERT_SAME(a_last_matches_kind, out_valid_i,
                   frame_last_i == (result_kind_i != wfr_pkg::KIND_MORE))

  `WFR_ASSERT_SAME(a_too_large_empty, out_valid_i && result_kind_i == wfr_pkg::KIND_TOO_LARGE,
                   payload_bytes_i == 3'd0 && payload_size_i == '0 && payload_word_i == '0)

  `WFR_ASSERT_SAME(a_bytes_in_range, out_valid_i, payload_bytes_i <= 3'd4)

endmodule

bind word_frame_receiver_crc16 wfr_checker #(
  .MAX_PAYLOAD (MAX_PAYLOAD)
) u_wfr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .result_kind_i   (result_kind_o),
  .command_type_i  (command_type_o),
  .payload_size_i  (payload_size_o),
  .payload_word_i  (payload_word_o),
  .payload_bytes_i (payload_bytes_o),
  .frame_last_i    (frame_last_o)
);

`default_nettype wire

/* tb/word_frame_receiver_crc16_checker.sv */
// Checker that predicts the results of the word frame receiver and compares them as they leave.
module word_frame_receiver_crc16_checker
  import wfr_pkg::*;
#(
  parameter int unsigned SizeW = $clog2(MAX_PAYLOAD + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [31:0]      link_word_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [1:0]       result_kind_i,
  input  logic [15:0]      command_type_i,
  input  logic [SizeW-1:0] payload_size_i,
  input  logic [31:0]      payload_word_i,
  input  logic [2:0]       payload_bytes_i,
  input  logic             frame_last_i,
  output int               mismatches_o,
  output int               pending_o
);

  typedef struct {
    result_kind_e     kind;
    logic [15:0]      command_type;
    logic [SizeW-1:0] payload_size;
    logic [31:0]      payload_word;
    logic [2:0]       payload_bytes;
    logic             frame_last;
  } frame_result_t;

  phase_e           frame_phase;
  logic [15:0]      held_type;
  logic [SizeW-1:0] held_size;
  int unsigned      bytes_due;
  logic [15:0]      crc_acc;
  logic [7:0]       crc_high;
  frame_result_t    due_results[$];

  function automatic logic [15:0] crc16_ccitt_byte(input logic [15:0] crc,
                                                   input logic [7:0] data);
    logic [15:0] acc;
    int          k;
    acc = crc ^ {data, 8'h00};
    for (k = 0; k < 8; k++) begin
      acc = acc[15] ? ((acc << 1) ^ 16'h1021) : (acc << 1);
    end
    return acc;
  endfunction

  function automatic bit deframe_word(input logic [31:0] word, output frame_result_t res);
    logic [7:0]  b;
    logic [15:0] sent_crc;
    int unsigned taken;
    bit          closing;
    int          i;
    if (frame_phase == PHASE_HEADER) begin
      if (word[15:0] > MAX_PAYLOAD) begin
        res.kind          = KIND_TOO_LARGE;
        res.command_type  = word[31:16];
        res.payload_size  = '0;
        res.payload_word  = '0;
        res.payload_bytes = '0;
        res.frame_last    = 1'b1;
        return 1'b1;
      end
      held_type = word[31:16];
      held_size = word[SizeW-1:0];
      bytes_due = word[15:0] + 2;
      crc_acc   = CRC_INIT;
      for (i = 3; i >= 0; i--) begin
        crc_acc = crc16_ccitt_byte(crc_acc, word[8*i +: 8]);
      end
      frame_phase = PHASE_BODY;
      return 1'b0;
    end
    taken            = 0;
    closing          = 1'b0;
    sent_crc         = '0;
    res.payload_word = '0;
    for (i = 3; i >= 0; i--) begin
      b = word[8*i +: 8];
      if (bytes_due > 2) begin
        crc_acc = crc16_ccitt_byte(crc_acc, b);
        res.payload_word[31 - 8*taken -: 8] = b;
        taken++;
        bytes_due--;
      end else if (bytes_due == 2) begin
        crc_high = b;
        bytes_due--;
      end else if (bytes_due == 1) begin
        sent_crc = {crc_high, b};
        bytes_due--;
        closing = 1'b1;
      end
    end
    res.command_type  = held_type;
    res.payload_size  = held_size;
    res.payload_bytes = 3'(taken);
    res.frame_last    = closing;
    res.kind          = !closing ? KIND_MORE : (sent_crc == crc_acc) ? KIND_GOOD : KIND_BAD_CRC;
    if (closing) begin
      frame_phase = PHASE_HEADER;
    end
    return 1'b1;
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    frame_result_t want;
    if (!rst_ni) begin
      frame_phase  = PHASE_HEADER;
      held_type    = '0;
      held_size    = '0;
      bytes_due    = 0;
      crc_acc      = CRC_INIT;
      crc_high     = '0;
      mismatches_o = 0;
      due_results.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        if (deframe_word(link_word_i, want)) begin
          due_results.push_back(want);
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (due_results.size() == 0) begin
          $error("result with no expectation pending: result_kind 0x%0h", result_kind_i);
          mismatches_o++;
        end else begin
          want = due_results.pop_front();
          compare_field("result_kind", 32'(want.kind), 32'(result_kind_i));
          compare_field("command_type", 32'(want.command_type), 32'(command_type_i));
          compare_field("payload_size", 32'(want.payload_size), 32'(payload_size_i));
          compare_field("payload_word", want.payload_word, payload_word_i);
          compare_field("payload_bytes", 32'(want.payload_bytes), 32'(payload_bytes_i));
          compare_field("frame_last", 32'(want.frame_last), 32'(frame_last_i));
        end
      end
    end
    pending_o = due_results.size();
  end

endmodule

/* tb/tb_word_frame_receiver_crc16.sv */
// Testbench top for the word frame receiver: frame stimulus, handshake pacing and the verdict.
module tb_word_frame_receiver_crc16;
  import wfr_pkg::*;

  localparam int unsigned SizeW       = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned ITEMS       = 1250;
  localparam int unsigned PAUSE_AT    = 650;
  localparam int unsigned CALM_FROM   = 1080;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned STALL_LIMIT = 2000;

  typedef enum int {
    FLAW_NONE,
    FLAW_CRC_HI,
    FLAW_CRC_LO,
    FLAW_PAYLOAD
  } flaw_e;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [31:0]      link_word_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [1:0]       result_kind_o;
  logic [15:0]      command_type_o;
  logic [SizeW-1:0] payload_size_o;
  logic [31:0]      payload_word_o;
  logic [2:0]       payload_bytes_o;
  logic             frame_last_o;

  int               mismatches;
  int               pending;
  int unsigned      words_sent = 0;
  int unsigned      gap_pct = 25;
  int unsigned      stall_pct = 25;
  int unsigned      hold_asked = 0;
  logic             calm = 1'b0;

  word_frame_receiver_crc16 dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .link_word_i    (link_word_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_kind_o  (result_kind_o),
    .command_type_o (command_type_o),
    .payload_size_o (payload_size_o),
    .payload_word_o (payload_word_o),
    .payload_bytes_o(payload_bytes_o),
    .frame_last_o   (frame_last_o)
  );

  word_frame_receiver_crc16_checker #(.SizeW(SizeW)) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .link_word_i    (link_word_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_kind_i  (result_kind_o),
    .command_type_i (command_type_o),
    .payload_size_i (payload_size_o),
    .payload_word_i (payload_word_o),
    .payload_bytes_i(payload_bytes_o),
    .frame_last_i   (frame_last_o),
    .mismatches_o   (mismatches),
    .pending_o      (pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [15:0] link_crc_step(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] acc;
    int          k;
    acc = crc ^ {data, 8'h00};
    for (k = 0; k < 8; k++) begin
      acc = acc[15] ? ((acc << 1) ^ 16'h1021) : (acc << 1);
    end
    return acc;
  endfunction

  function automatic int unsigned frame_size();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 88) return $urandom_range(24);
    if (roll < 99) return $urandom_range(120, 25);
    return $urandom_range(MAX_PAYLOAD, 900);
  endfunction

  task automatic push_word(input logic [31:0] word);
    if (!calm && $urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(15, 1)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    link_word_i <= word;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    words_sent++;
  endtask

  // A nonzero cut sends only that many words of the frame, header included.
  task automatic send_frame(input logic [15:0] ctype, input int unsigned size,
                            input flaw_e flaw, input int unsigned cut);
    logic [7:0]  frame_q[$];
    logic [15:0] crc;
    int unsigned at;
    int unsigned words;
    int unsigned k;
    frame_q.push_back(ctype[15:8]);
    frame_q.push_back(ctype[7:0]);
    frame_q.push_back(8'(size >> 8));
    frame_q.push_back(8'(size));
    repeat (size) frame_q.push_back(8'($urandom));
    crc = CRC_INIT;
    foreach (frame_q[i]) crc = link_crc_step(crc, frame_q[i]);
    if (flaw == FLAW_CRC_HI) crc[15:8] ^= 8'(1 << $urandom_range(7));
    if (flaw == FLAW_CRC_LO) crc[7:0] ^= 8'(1 << $urandom_range(7));
    if (flaw == FLAW_PAYLOAD) begin
      at = $urandom_range(size + 1);
      if (at > 1) at += 2;
      frame_q[at] ^= 8'(1 << $urandom_range(7));
    end
    frame_q.push_back(crc[15:8]);
    frame_q.push_back(crc[7:0]);
    while (frame_q.size() % 4 != 0) frame_q.push_back(8'($urandom));
    words = frame_q.size() / 4;
    if (cut != 0 && cut < words) words = cut;
    for (k = 0; k < words; k++) begin
      push_word({frame_q[4*k], frame_q[4*k+1], frame_q[4*k+2], frame_q[4*k+3]});
    end
  endtask

  initial begin : sink
    int unsigned holds_done;
    holds_done = 0;
    @(posedge rst_ni);
    forever begin
      if (hold_asked != holds_done) begin
        holds_done = hold_asked;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (!calm && $urandom_range(99) < stall_pct) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(15, 1)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    @(posedge rst_ni);
    while (idle < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle = 0;
      else idle++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int unsigned roll;
    int unsigned shape_mark;
    bit          paused;
    flaw_e       flaw;
    shape_mark = 0;
    paused     = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_frame(16'hFFFF, 0, FLAW_NONE, 0);
    send_frame(16'h0000, 0, FLAW_CRC_HI, 0);
    push_word({16'hA5A5, 16'(MAX_PAYLOAD + 1)});
    push_word(32'hFFFF_FFFF);
    send_frame(16'h0001, 1, FLAW_NONE, 0);
    send_frame(16'h8000, 2, FLAW_CRC_LO, 0);
    send_frame(16'h7FFF, 3, FLAW_NONE, 0);
    send_frame(16'h1234, 4, FLAW_PAYLOAD, 0);
    send_frame(16'hFEDC, 5, FLAW_NONE, 0);
    send_frame(16'h00FF, 6, FLAW_NONE, 0);
    // A frame cut short swallows the next frame as its own body.
    send_frame(16'h4242, 9, FLAW_NONE, 2);
    send_frame(16'h0F0F, 0, FLAW_NONE, 0);

    // The result sink holds out_ready_i low while the largest frame is offered.
    hold_asked <= hold_asked + 1;
    send_frame(16'h5AA5, MAX_PAYLOAD, FLAW_NONE, 0);

    while (words_sent < ITEMS) begin
      if (words_sent >= shape_mark) begin
        shape_mark = words_sent + 150;
        gap_pct   <= 20 * $urandom_range(3);
        stall_pct <= 20 * $urandom_range(3);
      end
      if (words_sent >= CALM_FROM) calm <= 1'b1;
      if (!paused && words_sent >= PAUSE_AT) begin
        paused = 1'b1;
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        wait (pending == 0);
        repeat (4) @(posedge clk_i);
      end
      flaw = FLAW_NONE;
      if ($urandom_range(4) == 0) flaw = flaw_e'($urandom_range(FLAW_PAYLOAD, FLAW_CRC_HI));
      roll = $urandom_range(99);
      if (roll < 70) begin
        send_frame(16'($urandom), frame_size(), flaw, 0);
      end else if (roll < 80) begin
        push_word({16'($urandom), 16'($urandom_range(16'hFFFF, MAX_PAYLOAD + 1))});
      end else if (roll < 90) begin
        send_frame(16'($urandom), frame_size(), flaw, $urandom_range(3, 1));
      end else begin
        repeat ($urandom_range(3, 1)) push_word($urandom);
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* word_frame_receiver_crc16.f */
+incdir+src
src/wfr_pkg.sv
src/wfr_in_reg.sv
src/wfr_deframe.sv
src/word_frame_receiver_crc16.sv
src/wfr_checker.sv
tb/word_frame_receiver_crc16_checker.sv
tb/tb_word_frame_receiver_crc16.sv
